// File: sv/hpet_pkg.sv
`default_nettype none
package hpet_pkg;

	// Number of comparator timers; the register map has room for six.
	localparam int NUM_TIMERS = 2;

	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int IRQ_W    = 2;
	localparam int COUNT_W  = 64;
	localparam int GEN_W    = 2;
	localparam int TCFG_W   = 10;

	// Commands
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	// Fixed register addresses; timer n sits at 4+2n (config) and 5+2n (compare)
	localparam logic [ADDR_W-1:0] ADDR_GEN_CFG  = 4'd0;
	localparam logic [ADDR_W-1:0] ADDR_STATUS   = 4'd1;
	localparam logic [ADDR_W-1:0] ADDR_COUNT_LO = 4'd2;
	localparam logic [ADDR_W-1:0] ADDR_COUNT_HI = 4'd3;
	localparam logic [ADDR_W-2:0] TIMER_BASE_PAIR = 3'd2;

	// Bit positions
	localparam int GEN_ENABLE_BIT   = 0;
	localparam int CFG_INT_ENB_BIT  = 1;
	localparam int CFG_PERIODIC_BIT = 2;
	localparam int CFG_VAL_SET_BIT  = 3;

	localparam logic [DATA_W-1:0] COMPARE_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] reg_addr;
		logic [DATA_W-1:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [IRQ_W-1:0]  irq_lines;
		logic              counter_running;
	} out_item_t;

endpackage
`default_nettype wire

// File: sv/hpet_two_timer_block.sv
`default_nettype none
// Channel   Handshake                   Payload                  Direction
// item      item_valid / item_stall     hpet_pkg::in_item_t      into block
// result    result_valid / result_stall hpet_pkg::out_item_t     out of block
//
// Every item gives exactly one result; it passes through the input register
// and then the result register.
// One item per cycle sustained while result is not stalled; the limit is
// the single-pass 64-bit counter increment and per-timer compare and period add.
// Reset puts the valid flags and block registers to reset values; no clearing pass.
// A stalled result holds the input register full, which then stalls item.
module hpet_two_timer_block (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire hpet_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output hpet_pkg::out_item_t      result
);

	localparam int NT = hpet_pkg::NUM_TIMERS;
	localparam int DW = hpet_pkg::DATA_W;

	// Input register
	logic               valid_s1;
	hpet_pkg::in_item_t item_s1;

	// Block state
	logic [hpet_pkg::COUNT_W-1:0] count_q;
	logic [hpet_pkg::GEN_W-1:0]   gen_q;
	logic [NT-1:0]                status_q;
	logic [hpet_pkg::TCFG_W-1:0]  cfg_q [NT];
	logic [DW-1:0]                cmp_q [NT];
	logic [DW-1:0]                per_q [NT];

	// Next state
	logic [hpet_pkg::COUNT_W-1:0] count_d;
	logic [hpet_pkg::GEN_W-1:0]   gen_d;
	logic [NT-1:0]                status_d;
	logic [hpet_pkg::TCFG_W-1:0]  cfg_d [NT];
	logic [DW-1:0]                cmp_d [NT];
	logic [DW-1:0]                per_d [NT];
	logic [DW-1:0]                rd_d;
	logic [hpet_pkg::IRQ_W-1:0]   irq_d;

	// Result register
	logic                valid_q;
	hpet_pkg::out_item_t result_q;

	logic advance;
	logic take_in;

	// The input register moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance      = valid_s1 && !(valid_q && result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign take_in      = item_valid && !item_stall;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	// Single-pass register update for the item in the input register
	always_comb begin
		count_d  = count_q;
		gen_d    = gen_q;
		status_d = status_q;
		rd_d     = '0;
		for (int n = 0; n < NT; n++) begin
			cfg_d[n] = cfg_q[n];
			cmp_d[n] = cmp_q[n];
			per_d[n] = per_q[n];
		end
		case (item_s1.command)
			hpet_pkg::CMD_TICK: begin
				// Advance only while enabled; compare against the new low word
				if (gen_q[hpet_pkg::GEN_ENABLE_BIT]) begin
					count_d = count_q + 64'd1;
					for (int n = 0; n < NT; n++) begin
						if (count_d[DW-1:0] == cmp_q[n]) begin
							if (cfg_q[n][hpet_pkg::CFG_INT_ENB_BIT]) begin
								status_d[n] = 1'b1;
							end
							if (cfg_q[n][hpet_pkg::CFG_PERIODIC_BIT]) begin
								cmp_d[n] = cmp_q[n] + per_q[n];
							end
						end
					end
				end
			end
			hpet_pkg::CMD_READ: begin
				case (item_s1.reg_addr)
					hpet_pkg::ADDR_GEN_CFG:  rd_d = DW'(gen_q);
					hpet_pkg::ADDR_STATUS:   rd_d = DW'(status_q);
					hpet_pkg::ADDR_COUNT_LO: rd_d = count_q[DW-1:0];
					hpet_pkg::ADDR_COUNT_HI: rd_d = count_q[2*DW-1:DW];
					default: begin
						// Timer registers; addresses past the last timer read zero
						for (int n = 0; n < NT; n++) begin
							if (item_s1.reg_addr[hpet_pkg::ADDR_W-1:1] ==
									hpet_pkg::TIMER_BASE_PAIR + 3'(n)) begin
								rd_d = item_s1.reg_addr[0] ? cmp_q[n] : DW'(cfg_q[n]);
							end
						end
					end
				endcase
			end
			hpet_pkg::CMD_WRITE: begin
				case (item_s1.reg_addr)
					hpet_pkg::ADDR_GEN_CFG:
						gen_d = item_s1.write_data[hpet_pkg::GEN_W-1:0];
					hpet_pkg::ADDR_STATUS:
						status_d = status_q & ~item_s1.write_data[NT-1:0];
					hpet_pkg::ADDR_COUNT_LO:
						count_d = {count_q[2*DW-1:DW], item_s1.write_data};
					hpet_pkg::ADDR_COUNT_HI:
						count_d = {item_s1.write_data, count_q[DW-1:0]};
					default: begin
						for (int n = 0; n < NT; n++) begin
							if (item_s1.reg_addr[hpet_pkg::ADDR_W-1:1] ==
									hpet_pkg::TIMER_BASE_PAIR + 3'(n)) begin
								if (item_s1.reg_addr[0]) begin
									// Comparator; with value-set on, also load the period
									cmp_d[n] = item_s1.write_data;
									if (cfg_q[n][hpet_pkg::CFG_VAL_SET_BIT]) begin
										per_d[n] = item_s1.write_data;
										cfg_d[n][hpet_pkg::CFG_VAL_SET_BIT] = 1'b0;
									end
								end else begin
									cfg_d[n] = item_s1.write_data[hpet_pkg::TCFG_W-1:0];
								end
							end
						end
					end
				endcase
			end
			default: begin
				// Unknown command: hold everything
			end
		endcase

		// Level interrupts from the updated state
		irq_d = '0;
		for (int n = 0; n < NT; n++) begin
			if (n < hpet_pkg::IRQ_W) begin
				irq_d[n] = status_d[n] & cfg_d[n][hpet_pkg::CFG_INT_ENB_BIT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			gen_q    <= '0;
			status_q <= '0;
			for (int n = 0; n < NT; n++) begin
				cfg_q[n] <= '0;
				cmp_q[n] <= hpet_pkg::COMPARE_RESET;
				per_q[n] <= '0;
			end
		end else if (advance) begin
			count_q  <= count_d;
			gen_q    <= gen_d;
			status_q <= status_d;
			for (int n = 0; n < NT; n++) begin
				cfg_q[n] <= cfg_d[n];
				cmp_q[n] <= cmp_d[n];
				per_q[n] <= per_d[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.read_data       <= rd_d;
			result_q.irq_lines       <= irq_d;
			result_q.counter_running <= gen_d[hpet_pkg::GEN_ENABLE_BIT];
		end
	end

	// Input side stalls only while the input register holds an item
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item stalled with empty input register");

	// Every processed item lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed item produced no result");

	// Reported running bit tracks the stored enable
	a_running_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.counter_running == gen_q[hpet_pkg::GEN_ENABLE_BIT])
		else $error("counter_running differs from enable bit");

	// A tick while disabled leaves the counter alone
	a_disabled_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == hpet_pkg::CMD_TICK &&
		!gen_q[hpet_pkg::GEN_ENABLE_BIT] |=> $stable(count_q))
		else $error("counter moved while disabled");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import hpet_pkg::*;

	// Command code the block must treat as a no-op; the package only names the real ones.
	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	// Highest address in the map: far past the last timer, so it must read zero.
	localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};
	localparam int unsigned       CYCLE_LIMIT = 200000;
	localparam int unsigned       STIM_TARGET = 550;
	// Extra settle time after the last result before calling the run done.
	localparam int unsigned       SETTLE_CYCLES = 8;
	localparam int unsigned       MAX_REPORTS = 10;

	typedef struct {
		in_item_t it;
		bit       wait_drain;   // hold this item back until every result is in
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	in_item_t  item = '0;
	logic      result_stall = 1'b0;
	logic      item_stall;
	logic      result_valid;
	out_item_t result;

	hpet_two_timer_block dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stim_t       cmd_queue[$];
	out_item_t   pending_results[$];
	int unsigned total_items = 0;
	int unsigned accepted_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	// Shadow copy of the timer block's registers
	logic [COUNT_W-1:0] shadow_count;
	logic [GEN_W-1:0]   shadow_gen;
	logic [IRQ_W-1:0]   shadow_status;
	logic [TCFG_W-1:0]  shadow_tcfg [NUM_TIMERS];
	logic [DATA_W-1:0]  shadow_cmp  [NUM_TIMERS];
	logic [DATA_W-1:0]  shadow_per  [NUM_TIMERS];

	initial begin
		shadow_count = '0;
		shadow_gen = '0;
		shadow_status = '0;
		for (int n = 0; n < NUM_TIMERS; n++) begin
			shadow_tcfg[n] = '0;
			shadow_cmp[n] = COMPARE_RESET;
			shadow_per[n] = '0;
		end
	end

	function automatic logic [ADDR_W-1:0] tcfg_addr(int t);
		return {(ADDR_W-1)'(TIMER_BASE_PAIR + t), 1'b0};
	endfunction

	function automatic logic [ADDR_W-1:0] tcmp_addr(int t);
		return {(ADDR_W-1)'(TIMER_BASE_PAIR + t), 1'b1};
	endfunction

	// Apply one accepted item to the shadow registers and return the result it must produce.
	task automatic timer_shadow_step(input in_item_t it, output out_item_t r);
		int                idx;
		logic [DATA_W-1:0] low;
		r = '0;
		idx = int'(it.reg_addr[ADDR_W-1:1]) - int'(TIMER_BASE_PAIR);
		case (it.command)
			CMD_TICK: begin
				// A tick while disabled leaves everything alone.
				if (shadow_gen[GEN_ENABLE_BIT]) begin
					shadow_count = shadow_count + 1'b1;
					low = shadow_count[DATA_W-1:0];
					for (int n = 0; n < NUM_TIMERS; n++) begin
						if (low == shadow_cmp[n]) begin
							if (shadow_tcfg[n][CFG_INT_ENB_BIT])
								shadow_status[n] = 1'b1;
							// A zero period leaves the comparator in place.
							if (shadow_tcfg[n][CFG_PERIODIC_BIT])
								shadow_cmp[n] = shadow_cmp[n] + shadow_per[n];
						end
					end
				end
			end
			CMD_READ: begin
				case (it.reg_addr)
					ADDR_GEN_CFG:  r.read_data = DATA_W'(shadow_gen);
					ADDR_STATUS:   r.read_data = DATA_W'(shadow_status);
					ADDR_COUNT_LO: r.read_data = shadow_count[DATA_W-1:0];
					ADDR_COUNT_HI: r.read_data = shadow_count[COUNT_W-1:DATA_W];
					default: begin
						if (idx < NUM_TIMERS)
							r.read_data = it.reg_addr[0] ? shadow_cmp[idx]
								: DATA_W'(shadow_tcfg[idx]);
					end
				endcase
			end
			CMD_WRITE: begin
				case (it.reg_addr)
					ADDR_GEN_CFG:  shadow_gen = it.write_data[GEN_W-1:0];
					ADDR_STATUS:   shadow_status = shadow_status & ~it.write_data[IRQ_W-1:0];
					ADDR_COUNT_LO: shadow_count[DATA_W-1:0] = it.write_data;
					ADDR_COUNT_HI: shadow_count[COUNT_W-1:DATA_W] = it.write_data;
					default: begin
						if (idx < NUM_TIMERS) begin
							if (it.reg_addr[0]) begin
								shadow_cmp[idx] = it.write_data;
								// Value-set also loads the period, then drops itself.
								if (shadow_tcfg[idx][CFG_VAL_SET_BIT]) begin
									shadow_per[idx] = it.write_data;
									shadow_tcfg[idx][CFG_VAL_SET_BIT] = 1'b0;
								end
							end else begin
								shadow_tcfg[idx] = it.write_data[TCFG_W-1:0];
							end
						end
					end
				endcase
			end
			default: ;
		endcase
		for (int n = 0; n < NUM_TIMERS; n++)
			r.irq_lines[n] = shadow_status[n] & shadow_tcfg[n][CFG_INT_ENB_BIT];
		r.counter_running = shadow_gen[GEN_ENABLE_BIT];
	endtask

	task automatic queue_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] data, bit wait_drain = 1'b0);
		stim_t s;
		s.it = '{command: cmd, reg_addr: addr, write_data: data};
		s.wait_drain = wait_drain;
		cmd_queue.push_back(s);
	endtask

	// Random word biased toward the all-zero and all-one extremes.
	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Typical driver flow: enable the counter, park it just short of a comparator,
	// arm the timer (optionally loading a short period) and tick through the match.
	task automatic queue_timer_scenario(bit wait_drain);
		int                t;
		int                ticks;
		int unsigned       pick;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] word;
		t = $urandom_range(NUM_TIMERS - 1);
		// Every so often sit right below the 32-bit rollover.
		base = ($urandom_range(3) == 0) ? (32'hFFFF_FFF0 + $urandom_range(15)) : $urandom;
		word = $urandom;
		word[GEN_ENABLE_BIT] = 1'b1;
		queue_item(CMD_WRITE, ADDR_GEN_CFG, word, wait_drain);
		if ($urandom_range(3) == 0)
			queue_item(CMD_WRITE, ADDR_COUNT_HI, rand_word());
		queue_item(CMD_WRITE, ADDR_COUNT_LO, base);
		word = $urandom;
		word[CFG_INT_ENB_BIT] = ($urandom_range(4) != 0);
		word[CFG_PERIODIC_BIT] = ($urandom_range(2) != 0);
		word[CFG_VAL_SET_BIT] = ($urandom_range(3) != 0);
		queue_item(CMD_WRITE, tcfg_addr(t), word);
		// With value-set on, this loads the period (zero included).
		queue_item(CMD_WRITE, tcmp_addr(t), $urandom_range(4));
		if ($urandom_range(4) != 0)
			queue_item(CMD_WRITE, tcmp_addr(t), base + 1 + $urandom_range(3));
		ticks = $urandom_range(4, 14);
		for (int k = 0; k < ticks; k++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				queue_item(CMD_TICK, ADDR_W'($urandom_range(15)), $urandom);
			else if (pick < 78)
				queue_item(CMD_READ, ($urandom_range(1) != 0) ? tcmp_addr(t) : ADDR_STATUS, '0);
			else if (pick < 88)
				queue_item(CMD_WRITE, ADDR_STATUS, rand_word());
			else if (pick < 93)
				queue_item(CMD_READ, ($urandom_range(1) != 0) ? tcfg_addr(t) : ADDR_COUNT_LO,
					$urandom);
			else if (pick < 97)
				// Break the sequence: may stop the counter midway.
				queue_item(CMD_WRITE, ADDR_GEN_CFG, $urandom);
			else
				queue_item(CMD_W'($urandom_range(3)), ADDR_W'($urandom_range(15)),
					rand_word());
		end
		queue_item(CMD_READ, ADDR_STATUS, '0);
	endtask

	function automatic int unsigned idle_phase();
		return (total_items == 0) ? 0 : accepted_cnt * 3 / total_items;
	endfunction

	// Sender idles 26% then 58%, receiver the other way round, then neither.
	function automatic int unsigned send_idle_pct();
		case (idle_phase())
			0:       return 26;
			1:       return 58;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct();
		case (idle_phase())
			0:       return 58;
			1:       return 26;
			default: return 0;
		endcase
	endfunction

	task automatic log_mismatch(string what, out_item_t want, out_item_t got);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("%0t %s: expected rd=%h irq=%b run=%b, got rd=%h irq=%b run=%b",
				$time, what, want.read_data, want.irq_lines, want.counter_running,
				got.read_data, got.irq_lines, got.counter_running);
	endtask

	// Driver: on a free slot, send the next queued item unless draining or idling.
	always @(posedge clk) begin
		stim_t     nxt;
		out_item_t want;
		bit        slot_free;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			slot_free = !item_valid;
			if (item_valid && !item_stall) begin
				timer_shadow_step(item, want);
				pending_results.push_back(want);
				accepted_cnt++;
				slot_free = 1'b1;
			end
			if (slot_free) begin
				if (cmd_queue.size() != 0
						&& !(cmd_queue[0].wait_drain && pending_results.size() != 0)
						&& $urandom_range(99) >= send_idle_pct()) begin
					nxt = cmd_queue.pop_front();
					item_valid <= 1'b1;
					item <= nxt.it;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check every accepted result against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					log_mismatch("unexpected result", '0, result);
				end else begin
					want = pending_results.pop_front();
					if (result.read_data !== want.read_data
							|| result.irq_lines !== want.irq_lines
							|| result.counter_running !== want.counter_running)
						log_mismatch("result mismatch", want, result);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct());
		end
	end

	// Watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("hpet_two_timer_block regression: fail");
		$finish;
	end

	initial begin
		// Directed: reset values, unused address and command, 64-bit wrap,
		// periodic reload with a full-range period, zero period, status clears.
		queue_item(CMD_TICK, ADDR_GEN_CFG, '0);
		queue_item(CMD_READ, tcmp_addr(0), '0);
		queue_item(CMD_READ, ADDR_LAST, '1);
		queue_item(CMD_WRITE, ADDR_LAST, '1);
		queue_item(CMD_UNUSED, ADDR_GEN_CFG, '1);
		queue_item(CMD_WRITE, ADDR_GEN_CFG, '1);
		queue_item(CMD_WRITE, ADDR_COUNT_LO, 32'hFFFF_FFFE);
		queue_item(CMD_WRITE, ADDR_COUNT_HI, '1);
		queue_item(CMD_WRITE, tcfg_addr(0), '1);
		queue_item(CMD_WRITE, tcmp_addr(0), '1);
		queue_item(CMD_READ, tcfg_addr(0), '0);
		queue_item(CMD_TICK, ADDR_LAST, '1);
		queue_item(CMD_TICK, ADDR_GEN_CFG, '0);
		queue_item(CMD_READ, ADDR_COUNT_LO, '0);
		queue_item(CMD_READ, ADDR_COUNT_HI, '0);
		queue_item(CMD_READ, ADDR_STATUS, '0, 1'b1);
		queue_item(CMD_WRITE, ADDR_STATUS, '0);
		queue_item(CMD_WRITE, ADDR_STATUS, '1);
		queue_item(CMD_WRITE, tcfg_addr(1),
			DATA_W'((1 << CFG_INT_ENB_BIT) | (1 << CFG_PERIODIC_BIT)));
		queue_item(CMD_WRITE, tcmp_addr(1), 32'd2);
		queue_item(CMD_TICK, ADDR_GEN_CFG, '0);
		queue_item(CMD_TICK, ADDR_GEN_CFG, '0);
		queue_item(CMD_READ, tcmp_addr(1), '0);
		queue_item(CMD_WRITE, ADDR_GEN_CFG, '0);
		queue_item(CMD_READ, ADDR_GEN_CFG, '0);

		// Random: mostly armed-timer sequences, the rest loose noise.
		queue_timer_scenario(1'b1);
		while (cmd_queue.size() < STIM_TARGET) begin
			if ($urandom_range(99) < 70) begin
				queue_timer_scenario($urandom_range(7) == 0);
			end else begin
				repeat ($urandom_range(1, 4))
					queue_item(CMD_W'($urandom_range(3)), ADDR_W'($urandom_range(15)),
						rand_word());
			end
		end
		total_items = cmd_queue.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < total_items || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		err_cnt += pending_results.size();

		if (err_cnt == 0)
			$display("hpet_two_timer_block regression: pass");
		else
			$display("hpet_two_timer_block regression: fail");
		$finish;
	end

endmodule
